// ===== design/itsb_pkg.sv =====
// Shared types and constants for the interval timer statistics bank.
package itsb_pkg;

   localparam int START_SLOTS_DEF  = 16;
   localparam int STAT_ENTRIES_DEF = 16;

   localparam logic [63:0] MIN_RESET = 64'h8000_0000_0000_0000;

   typedef enum logic [1:0] {
      FUNC_START = 2'd0,
      FUNC_LAP   = 2'd1,
      FUNC_CATCH = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_UPDATE
   } state_type;

   // request tdata, lowest field last
   typedef struct packed {
      logic [5:0]  pad;
      logic [63:0] cycle_now;
      logic [7:0]  slot;
      func_type    func;
   } req_payload_type;

   // response tdata, lowest field last
   typedef struct packed {
      logic [5:0]  pad;
      logic        has_samples;
      logic [31:0] zero_laps;
      logic [63:0] greatest;
      logic [63:0] least;
      logic [63:0] sum_total;
      logic [63:0] stamp;
      logic [63:0] elapsed;
      logic        index_ok;
   } rsp_payload_type;

   // one statistics entry as held in memory
   typedef struct packed {
      logic [31:0] zero_count;
      logic [63:0] max;
      logic [63:0] min;
      logic [63:0] total;
   } stat_entry_type;

   localparam int STAT_WIDTH = $bits(stat_entry_type);

   localparam stat_entry_type STAT_RESET = '{
      zero_count: 32'd0,
      max:        64'd0,
      min:        MIN_RESET,
      total:      64'd0
   };

endpackage

// ===== design/interval_timer_statistics_bank.sv =====
// Top level of the interval timer statistics bank.
//
// A bank of stopwatch timers with per-entry interval statistics. Each request
// transfer carries a function code, a slot and a 64-bit cycle stamp: start
// stores the stamp in a start slot, lap returns stamp minus a start slot,
// catch takes the lap against start slot 0 and folds it into statistics entry
// "slot" (max, min, wrapping total, count of zero laps) and returns lap and
// stamp, read returns one statistics entry. A slot at or beyond START_SLOTS
// (start, lap) or STAT_ENTRIES (catch, read) is accepted and dropped with no
// response. Start stamps and statistics live in two synchronous RAMs;
// per-entry valid flops, cleared by reset, make unwritten entries read as
// their reset values, so no clearing pass is needed. Each in-range item passes
// RAM read issue at acceptance, the lap subtract, then the compare/add update
// with write-back and the load of the response register. The update cycle
// waits while that register still holds an untaken response; a new request is
// accepted once the update is done, even if the response is still pending.
module interval_timer_statistics_bank
   import itsb_pkg::*;
#(
   parameter int START_SLOTS  = START_SLOTS_DEF,
   parameter int STAT_ENTRIES = STAT_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // func[1:0], slot[9:2], cycle_now[73:10], zero pad[79:74]
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // index_ok[0], elapsed[64:1], stamp[128:65], sum_total[192:129],
   // least[256:193], greatest[320:257], zero_laps[352:321], has_samples[353],
   // zero pad[359:354]
   output logic [359:0] rsp_tdata
);

   localparam int SW = (START_SLOTS > 1) ? $clog2(START_SLOTS) : 1;
   localparam int TW = (STAT_ENTRIES > 1) ? $clog2(STAT_ENTRIES) : 1;
   localparam logic [8:0] START_LIM = 9'(START_SLOTS);
   localparam logic [8:0] STAT_LIM  = 9'(STAT_ENTRIES);

   req_payload_type req;
   logic            accept;
   logic            start_ok;
   logic            stat_ok;
   logic            in_range;
   logic            out_free;

   state_type state_ff, state_in;

   // item held while it is worked on
   func_type    func_ff;
   logic [7:0]  slot_ff;
   logic [63:0] now_ff;

   logic [SW-1:0] start_rd_addr;
   logic [TW-1:0] stat_rd_addr;
   logic [SW-1:0] start_wr_addr;
   logic [TW-1:0] stat_wr_addr;

   logic [START_SLOTS-1:0]  start_valid_ff, start_valid_in;
   logic [STAT_ENTRIES-1:0] stat_valid_ff, stat_valid_in;
   logic                    start_hit_ff;
   logic                    stat_hit_ff;

   logic [63:0]          start_rd_data;
   logic [STAT_WIDTH-1:0] stat_rd_data;

   logic [63:0]    lap_ff;
   stat_entry_type entry_ff;
   stat_entry_type entry_new;
   logic [63:0]    start_val;

   logic rd_en;
   logic start_we;
   logic stat_we;
   logic rsp_load;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_build;

   assign req      = req_payload_type'(req_tdata);
   assign accept   = req_tvalid && req_tready;
   assign start_ok = {1'b0, req.slot} < START_LIM;
   assign stat_ok  = {1'b0, req.slot} < STAT_LIM;
   assign in_range = (req.func inside {FUNC_START, FUNC_LAP}) ? start_ok : stat_ok;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && in_range) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD:   state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      start_we   = 1'b0;
      stat_we    = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            rd_en      = accept && in_range;
         end
         ST_UPDATE: begin
            rsp_load = out_free;
            start_we = out_free && (func_ff == FUNC_START);
            stat_we  = out_free && (func_ff == FUNC_CATCH);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_valid_ff <= '0;
         stat_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_valid_ff <= start_valid_in;
         stat_valid_ff  <= stat_valid_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- memories ----------------
   // catch always measures against start slot 0
   assign start_rd_addr = (req.func == FUNC_CATCH) ? '0 : req.slot[SW-1:0];
   assign stat_rd_addr  = req.slot[TW-1:0];
   assign start_wr_addr = slot_ff[SW-1:0];
   assign stat_wr_addr  = slot_ff[TW-1:0];

   always_comb begin
      start_valid_in = start_valid_ff;
      stat_valid_in  = stat_valid_ff;
      if (start_we) begin
         start_valid_in[start_wr_addr] = 1'b1;
      end
      if (stat_we) begin
         stat_valid_in[stat_wr_addr] = 1'b1;
      end
   end

   itsb_ram #(
      .WIDTH(64),
      .DEPTH(START_SLOTS)
   ) u_start_ram (
      .clock  (clock),
      .wr_en  (start_we),
      .wr_addr(start_wr_addr),
      .wr_data(now_ff),
      .rd_en  (rd_en),
      .rd_addr(start_rd_addr),
      .rd_data(start_rd_data)
   );

   itsb_ram #(
      .WIDTH(STAT_WIDTH),
      .DEPTH(STAT_ENTRIES)
   ) u_stat_ram (
      .clock  (clock),
      .wr_en  (stat_we),
      .wr_addr(stat_wr_addr),
      .wr_data(entry_new),
      .rd_en  (rd_en),
      .rd_addr(stat_rd_addr),
      .rd_data(stat_rd_data)
   );

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      if (rd_en) begin
         func_ff      <= req.func;
         slot_ff      <= req.slot;
         now_ff       <= req.cycle_now;
         start_hit_ff <= start_valid_ff[start_rd_addr];
         stat_hit_ff  <= stat_valid_ff[stat_rd_addr];
      end
   end

   assign start_val = start_hit_ff ? start_rd_data : 64'd0;

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         lap_ff   <= now_ff - start_val;
         entry_ff <= stat_hit_ff ? stat_entry_type'(stat_rd_data) : STAT_RESET;
      end
   end

   always_comb begin
      entry_new            = entry_ff;
      entry_new.total      = entry_ff.total + lap_ff;
      entry_new.max        = (lap_ff > entry_ff.max) ? lap_ff : entry_ff.max;
      entry_new.min        = (lap_ff < entry_ff.min) ? lap_ff : entry_ff.min;
      entry_new.zero_count = entry_ff.zero_count + 32'(lap_ff == 64'd0);
   end

   always_comb begin
      rsp_build          = '0;
      rsp_build.index_ok = 1'b1;
      case (func_ff)
         FUNC_LAP:   rsp_build.elapsed = lap_ff;
         FUNC_CATCH: begin
            rsp_build.elapsed = lap_ff;
            rsp_build.stamp   = now_ff;
         end
         FUNC_READ: begin
            rsp_build.sum_total   = entry_ff.total;
            rsp_build.least       = entry_ff.min;
            rsp_build.greatest    = entry_ff.max;
            rsp_build.zero_laps   = entry_ff.zero_count;
            rsp_build.has_samples = entry_ff.min != MIN_RESET;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_build;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- checks ----------------
   a_drop_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && !in_range) |=> (state_ff == ST_IDLE))
      else $error("out-of-range item left idle");

   a_load_to_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> (state_ff == ST_UPDATE))
      else $error("load not followed by update");

   a_stat_write_catch: assert property (@(posedge clock) disable iff (reset)
      stat_we |-> (state_ff == ST_UPDATE && func_ff == FUNC_CATCH))
      else $error("statistics write outside catch update");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending response overwritten");

endmodule

// ===== design/itsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module itsb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
